// ----- design/swmf_pkg.sv -----
package swmf_pkg;

   localparam int WINDOW_DEFAULT = 7;
   localparam int SAMPLE_W       = 16;
   localparam int MEDIAN_W       = 17;
   localparam int COUNT_W        = 3;

   typedef enum logic [1:0] {
      S_IDLE,
      S_RANK,
      S_FINISH
   } state_type;

   // controls for the rank lanes
   typedef struct packed {
      logic clear;
      logic step;
   } rank_ctl_type;

endpackage

// ----- design/sliding_window_median_filter.sv -----
// a taken request is ranked, then its median waits in FINISH until the output register is free
// no new request is taken until that result is loaded; count = samples in the window (1..WINDOW)
// the rank loop sends one stored sample per cycle past the shared compare row
// reset (synchronous, active high) clears the sequencer, write position, full flag
// and the output valid; the sample store keeps its contents and needs no clearing
module sliding_window_median_filter #(
   parameter int WINDOW = swmf_pkg::WINDOW_DEFAULT
) (
   input  logic                                   clock,
   input  logic                                   reset,
   input  logic                                   req_valid,
   output logic                                   req_ready,
   input  logic signed [swmf_pkg::SAMPLE_W-1:0]   req_sample,
   output logic                                   rsp_valid,
   input  logic                                   rsp_ready,
   output logic signed [swmf_pkg::MEDIAN_W-1:0]   rsp_median_twice,
   output logic        [swmf_pkg::COUNT_W-1:0]    rsp_valid_count
);

   localparam int PW = (WINDOW > 1) ? $clog2(WINDOW) : 1;   // position / index width
   localparam int CW = $clog2(WINDOW + 1);                 // count width

   // sequencer
   swmf_pkg::state_type state_ff, state_in;

   // window state
   logic signed [swmf_pkg::SAMPLE_W-1:0] store_ff [WINDOW];
   logic [PW-1:0] wp_ff, wp_in;
   logic          full_ff, full_in;

   // per-request working registers
   logic [CW-1:0] count_ff, count_in;
   logic [PW-1:0] idx_ff, idx_in;

   // output register
   logic                                 rsp_valid_ff, rsp_valid_in;
   logic signed [swmf_pkg::MEDIAN_W-1:0] median_ff, median_in;
   logic        [swmf_pkg::COUNT_W-1:0]  vcount_ff, vcount_in;

   // control
   logic                   req_accept;
   logic                   wrap;
   logic                   last_cand;
   logic                   rsp_free;
   logic                   load_rsp;
   swmf_pkg::rank_ctl_type rank_ctl;

   // rank lanes
   logic signed [swmf_pkg::SAMPLE_W-1:0] cand;
   logic [CW-1:0] lt_cnt [WINDOW];
   logic [CW-1:0] le_cnt [WINDOW];

   // median selection
   logic [CW-1:0]                        ka, kb;
   logic signed [swmf_pkg::SAMPLE_W-1:0] va, vb;

   assign req_accept = req_valid && req_ready;
   assign wrap       = (wp_ff == PW'(WINDOW - 1));
   assign last_cand  = ((CW'(idx_ff) + CW'(1)) == count_ff);
   assign rsp_free   = !rsp_valid_ff || rsp_ready;

   // next state
   always_comb begin
      state_in = state_ff;
      case (state_ff)
         swmf_pkg::S_IDLE: begin
            if (req_accept) state_in = swmf_pkg::S_RANK;
         end
         swmf_pkg::S_RANK: begin
            if (last_cand) state_in = swmf_pkg::S_FINISH;
         end
         swmf_pkg::S_FINISH: begin
            if (rsp_free) state_in = swmf_pkg::S_IDLE;
         end
         default: state_in = swmf_pkg::S_IDLE;
      endcase
   end

   // sequencer outputs
   always_comb begin
      req_ready      = 1'b0;
      rank_ctl.clear = 1'b0;
      rank_ctl.step  = 1'b0;
      load_rsp       = 1'b0;
      case (state_ff)
         swmf_pkg::S_IDLE: begin
            req_ready      = 1'b1;
            rank_ctl.clear = 1'b1;
         end
         swmf_pkg::S_RANK: begin
            rank_ctl.step = 1'b1;
         end
         swmf_pkg::S_FINISH: begin
            load_rsp = rsp_free;
         end
         default: begin
            req_ready = 1'b0;
         end
      endcase
   end

   // window bookkeeping: position wraps to zero, first wrap marks the window full
   always_comb begin
      wp_in    = wp_ff;
      full_in  = full_ff;
      count_in = count_ff;
      if (req_accept) begin
         wp_in    = wrap ? '0 : wp_ff + PW'(1);
         full_in  = full_ff || wrap;
         count_in = (full_ff || wrap) ? CW'(WINDOW) : CW'(wp_ff) + CW'(1);
      end
   end

   // candidate index walks 0..count-1 during ranking
   always_comb begin
      idx_in = idx_ff;
      if (req_accept) begin
         idx_in = '0;
      end else if (state_ff == swmf_pkg::S_RANK) begin
         idx_in = idx_ff + PW'(1);
      end
   end

   assign cand = store_ff[idx_ff];

   swmf_rank #(
      .WINDOW (WINDOW),
      .CW     (CW)
   ) u_rank (
      .clock  (clock),
      .ctl    (rank_ctl),
      .cand   (cand),
      .store  (store_ff),
      .lt_cnt (lt_cnt),
      .le_cnt (le_cnt)
   );

   // sorted positions of the two middle values (equal for an odd count)
   assign ka = (count_ff - CW'(1)) >> 1;
   assign kb = count_ff >> 1;

   // a lane holds sorted position k when lt <= k < le; tied lanes carry equal
   // values, so or-ing all hits still gives that value
   always_comb begin
      va = '0;
      vb = '0;
      for (int j = 0; j < WINDOW; j++) begin
         if (CW'(j) < count_ff) begin
            if ((lt_cnt[j] <= ka) && (ka < le_cnt[j])) va = va | store_ff[j];
            if ((lt_cnt[j] <= kb) && (kb < le_cnt[j])) vb = vb | store_ff[j];
         end
      end
   end

   // output register, held until the consumer takes it
   always_comb begin
      rsp_valid_in = rsp_valid_ff;
      median_in    = median_ff;
      vcount_in    = vcount_ff;
      if (rsp_valid_ff && rsp_ready) rsp_valid_in = 1'b0;
      if (load_rsp) begin
         rsp_valid_in = 1'b1;
         median_in    = {va[swmf_pkg::SAMPLE_W-1], va} + {vb[swmf_pkg::SAMPLE_W-1], vb};
         vcount_in    = swmf_pkg::COUNT_W'(count_ff);
      end
   end

   // control registers
   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff     <= swmf_pkg::S_IDLE;
         wp_ff        <= '0;
         full_ff      <= 1'b0;
         rsp_valid_ff <= 1'b0;
      end else begin
         state_ff     <= state_in;
         wp_ff        <= wp_in;
         full_ff      <= full_in;
         rsp_valid_ff <= rsp_valid_in;
      end
   end

   // payload registers
   always_ff @(posedge clock) begin
      count_ff  <= count_in;
      idx_ff    <= idx_in;
      median_ff <= median_in;
      vcount_ff <= vcount_in;
   end

   // sample store, one write per request
   always_ff @(posedge clock) begin
      if (req_accept) store_ff[wp_ff] <= req_sample;
   end

   assign rsp_valid        = rsp_valid_ff;
   assign rsp_median_twice = median_ff;
   assign rsp_valid_count  = vcount_ff;

   // a taken request starts ranking at the first candidate
   a_start_rank: assert property (@(posedge clock) disable iff (reset)
      req_accept |=> (state_ff == swmf_pkg::S_RANK) && (idx_ff == '0))
      else $error("ranking did not start at candidate zero");

   // ranking ends after exactly count candidates
   a_rank_end: assert property (@(posedge clock) disable iff (reset)
      (state_ff == swmf_pkg::S_RANK) && last_cand |=> state_ff == swmf_pkg::S_FINISH)
      else $error("rank loop overran the valid count");

   // count stays within the window while a request is in progress
   a_count_range: assert property (@(posedge clock) disable iff (reset)
      (state_ff != swmf_pkg::S_IDLE) |-> (count_ff != '0) && (count_ff <= CW'(WINDOW)))
      else $error("valid count out of range");

   // a finished result lands in the output register and frees the sequencer
   a_finish_load: assert property (@(posedge clock) disable iff (reset)
      (state_ff == swmf_pkg::S_FINISH) && rsp_free |=> rsp_valid_ff &&
      (state_ff == swmf_pkg::S_IDLE))
      else $error("result not loaded on finish");

endmodule

// ----- design/swmf_rank.sv -----
// one lane per stored sample, each keeps how many candidates rank below it
module swmf_rank #(
   parameter int WINDOW = swmf_pkg::WINDOW_DEFAULT,
   parameter int CW     = $clog2(WINDOW + 1)
) (
   input  logic                                    clock,
   input  swmf_pkg::rank_ctl_type                  ctl,
   input  logic signed [swmf_pkg::SAMPLE_W-1:0]    cand,
   input  logic signed [swmf_pkg::SAMPLE_W-1:0]    store [WINDOW],
   output logic        [CW-1:0]                    lt_cnt [WINDOW],
   output logic        [CW-1:0]                    le_cnt [WINDOW]
);

   logic [CW-1:0] lt_ff [WINDOW];
   logic [CW-1:0] le_ff [WINDOW];

   always_ff @(posedge clock) begin
      for (int j = 0; j < WINDOW; j++) begin
         if (ctl.clear) begin
            lt_ff[j] <= '0;
            le_ff[j] <= '0;
         end else if (ctl.step) begin
            lt_ff[j] <= lt_ff[j] + CW'(cand <  store[j]);
            le_ff[j] <= le_ff[j] + CW'(cand <= store[j]);
         end
      end
   end

   assign lt_cnt = lt_ff;
   assign le_cnt = le_ff;

endmodule
